// ===== hdl/lru_key_value_cache_assert.svh =====
// ----------------------------------------------------------------------------
// lru key/value cache assertion macros
// concurrent checks on a named clock and reset
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// same-cycle implication
`define LKVC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LKVC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lru key/value cache package
// shared widths, defaults, action codes and sequencer states
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkvc_pkg;

   localparam int ENTRIES_DEF  = 16;
   localparam int KEY_BITS_DEF = 32;
   localparam int DATA_W       = 32;
   localparam int CAP_W        = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic ACT_GET = 1'b0;
   localparam logic ACT_SET = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_RESP
   } state_type;

endpackage

// ===== hdl/lkvc_req_if.sv =====
// ----------------------------------------------------------------------------
// lru key/value cache request channel
// valid/ready channel carrying one get or set word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lkvc_req_if;
   import lkvc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     action;
   logic signed [DATA_W-1:0] lookup_key;
   logic signed [DATA_W-1:0] write_value;

   modport source (output valid, output action, output lookup_key, output write_value,
                   input ready);
   modport sink   (input valid, input action, input lookup_key, input write_value,
                   output ready);
endinterface

// ===== hdl/lkvc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lru key/value cache response channel
// valid/ready channel carrying one lookup result word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lkvc_rsp_if;
   import lkvc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     found;
   logic signed [DATA_W-1:0] read_value;

   modport source (output valid, output found, output read_value, input ready);
   modport sink   (input valid, input found, input read_value, output ready);
endinterface

// ===== hdl/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru key/value cache
// key/value store with least-recently-used replacement up to a set capacity
//
//   channel   direction  word
//   req_bus   in         action, lookup_key, write_value
//   rsp_bus   out        found, read_value (one per get)
//   csr_*     in         capacity write, no read-back
//
// each word sweeps the key/value memory once and, on a hit
// or a set, sweeps the rank memory once more with read-modify-write
// synchronous active-high reset clears valid bits and count, capacity back to 16
// a waiting response word does not block the next request, but a later get
// holds in its response state until that word is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_key_value_cache #(
   parameter int ENTRIES  = lkvc_pkg::ENTRIES_DEF,
   parameter int KEY_BITS = lkvc_pkg::KEY_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   lkvc_req_if.sink                   req_bus,
   lkvc_rsp_if.source                 rsp_bus,
   input  logic                       csr_wr_en,
   input  logic [lkvc_pkg::CAP_W-1:0] csr_wr_data
);
   import lkvc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int ENT_W = KEY_BITS + DATA_W;

   // memories
   logic [ENT_W-1:0] entry_mem [ENTRIES];
   logic [IDX_W-1:0] rank_mem  [ENTRIES];

   logic [ENT_W-1:0] ent_rd_ff;
   logic [IDX_W-1:0] rank_rd_ff;

   logic             ent_we;
   logic             rank_we;
   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] wr_idx;
   logic [ENT_W-1:0] ent_wdata;
   logic [IDX_W-1:0] rank_wdata;

   // control
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             stg_vld_ff, stg_vld_in;
   logic [IDX_W-1:0] stg_idx_ff, stg_idx_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0] hit_rank_ff, hit_rank_in;
   logic [DATA_W-1:0] hit_val_ff, hit_val_in;
   logic             slot_done_ff, slot_done_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CAP_W-1:0] cap_ff;
   logic             rsp_vld_ff, rsp_vld_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [DATA_W-1:0] rsp_val_ff, rsp_val_in;

   // request word
   logic              act_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [DATA_W-1:0] val_ff;
   logic [63:0]       key_sx;
   logic              req_acc;

   // sweep helpers
   logic [CMP_W-1:0] cap_ext;
   logic [CMP_W-1:0] cap_eff;
   logic [CMP_W-1:0] cap_m1;
   logic             full;
   logic             cnt_end;
   logic             stg_valid_bit;
   logic             key_match;
   logic             evict;
   logic             hit_now;

   assign key_sx  = {{(64 - DATA_W){req_bus.lookup_key[DATA_W-1]}}, req_bus.lookup_key};
   assign req_acc = req_bus.valid && (state_ff == ST_IDLE);

   assign cap_ext = CMP_W'(cap_ff);
   assign cap_eff = (cap_ext == '0) ? CMP_W'(1) :
                    (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
   assign cap_m1  = cap_eff - CMP_W'(1);
   assign full    = CMP_W'(used_ff) >= cap_eff;
   assign cnt_end = (cnt_ff == CNT_W'(ENTRIES));

   assign stg_valid_bit = valid_ff[stg_idx_ff];
   assign key_match     = (ent_rd_ff[ENT_W-1:DATA_W] == key_ff);
   assign evict         = full && stg_valid_bit && (CMP_W'(rank_rd_ff) >= cap_m1);

   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign rsp_bus.valid      = rsp_vld_ff;
   assign rsp_bus.found      = rsp_found_ff;
   assign rsp_bus.read_value = rsp_val_ff;

   always_ff @(posedge clock) begin
      if (ent_we) begin
         entry_mem[wr_idx] <= ent_wdata;
      end
      ent_rd_ff <= entry_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (rank_we) begin
         rank_mem[wr_idx] <= rank_wdata;
      end
      rank_rd_ff <= rank_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         stg_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         slot_done_ff <= 1'b0;
         valid_ff     <= '0;
         used_ff      <= '0;
         cap_ff       <= CAP_RESET;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         stg_vld_ff   <= stg_vld_in;
         hit_ff       <= hit_in;
         slot_done_ff <= slot_done_in;
         valid_ff     <= valid_in;
         used_ff      <= used_in;
         rsp_vld_ff   <= rsp_vld_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      stg_idx_ff   <= stg_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_rank_ff  <= hit_rank_in;
      hit_val_ff   <= hit_val_in;
      rsp_found_ff <= rsp_found_in;
      rsp_val_ff   <= rsp_val_in;
      if (req_acc) begin
         act_ff <= req_bus.action;
         key_ff <= key_sx[KEY_BITS-1:0];
         val_ff <= req_bus.write_value;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      stg_vld_in   = 1'b0;
      stg_idx_in   = cnt_ff[IDX_W-1:0];
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_rank_in  = hit_rank_ff;
      hit_val_in   = hit_val_ff;
      slot_done_in = slot_done_ff;
      valid_in     = valid_ff;
      used_in      = used_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_bus.ready;
      rsp_found_in = rsp_found_ff;
      rsp_val_in   = rsp_val_ff;
      ent_we       = 1'b0;
      rank_we      = 1'b0;
      rd_idx       = cnt_ff[IDX_W-1:0];
      wr_idx       = stg_idx_ff;
      ent_wdata    = {key_ff, val_ff};
      rank_wdata   = '0;
      hit_now      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in     = ST_SCAN;
               cnt_in       = '0;
               hit_in       = 1'b0;
               slot_done_in = 1'b0;
            end
         end

         ST_SCAN: begin
            if (!cnt_end) begin
               stg_vld_in = 1'b1;
               cnt_in     = cnt_ff + CNT_W'(1);
            end
            hit_now = stg_vld_ff && stg_valid_bit && key_match && !hit_ff;
            if (hit_now) begin
               hit_in      = 1'b1;
               hit_idx_in  = stg_idx_ff;
               hit_rank_in = rank_rd_ff;
               hit_val_in  = ent_rd_ff[DATA_W-1:0];
            end
            if (cnt_end) begin
               cnt_in = '0;
               if ((act_ff == ACT_GET) && !(hit_ff || hit_now)) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end

         ST_UPDATE: begin
            if (!cnt_end) begin
               stg_vld_in = 1'b1;
               cnt_in     = cnt_ff + CNT_W'(1);
            end
            if (stg_vld_ff) begin
               if (hit_ff) begin
                  if (stg_idx_ff == hit_idx_ff) begin
                     rank_we    = 1'b1;
                     rank_wdata = '0;
                     ent_we     = (act_ff == ACT_SET);
                  end else if (stg_valid_bit && (rank_rd_ff < hit_rank_ff)) begin
                     rank_we    = 1'b1;
                     rank_wdata = rank_rd_ff + IDX_W'(1);
                  end
               end else begin
                  if ((!stg_valid_bit || evict) && !slot_done_ff) begin
                     // first free or freed entry takes the new key
                     slot_done_in         = 1'b1;
                     valid_in[stg_idx_ff] = 1'b1;
                     ent_we               = 1'b1;
                     rank_we              = 1'b1;
                     rank_wdata           = '0;
                  end else if (evict) begin
                     valid_in[stg_idx_ff] = 1'b0;
                  end else if (stg_valid_bit) begin
                     rank_we    = 1'b1;
                     rank_wdata = rank_rd_ff + IDX_W'(1);
                  end
               end
            end
            if (cnt_end) begin
               cnt_in = '0;
               if (!hit_ff) begin
                  used_in = full ? CNT_W'(cap_eff) : used_ff + CNT_W'(1);
               end
               state_in = (act_ff == ACT_GET) ? ST_RESP : ST_IDLE;
            end
         end

         ST_RESP: begin
            if (!rsp_vld_ff || rsp_bus.ready) begin
               rsp_vld_in   = 1'b1;
               rsp_found_in = hit_ff;
               rsp_val_in   = hit_ff ? hit_val_ff : '0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`include "lru_key_value_cache_assert.svh"

   `LKVC_ASSERT_IMPL(a_used_matches_valid, clock, reset, state_ff == ST_IDLE, $countones(valid_ff) == used_ff, "entry count disagrees with valid bits")
   `LKVC_ASSERT_IMPL(a_hit_entry_valid, clock, reset, (state_ff == ST_UPDATE) && stg_vld_ff && hit_ff && (stg_idx_ff == hit_idx_ff), stg_valid_bit, "hit entry not valid during update")
   `LKVC_ASSERT_IMPL(a_insert_slot_found, clock, reset, (state_ff == ST_UPDATE) && cnt_end && !hit_ff, slot_done_in, "no free entry found for insertion")
   `LKVC_ASSERT_NEXT(a_resp_loaded, clock, reset, (state_ff == ST_RESP) && !(rsp_vld_ff && !rsp_bus.ready), rsp_vld_ff && (state_ff == ST_IDLE), "response word not loaded")

endmodule

// ===== dv/lkvc_checker.sv =====
// ----------------------------------------------------------------------------
// lru key/value cache lookup checker
// watches the request, response and capacity ports, keeps its own copy of the
// cache contents and recency order, and compares every response word with
// the oldest predicted lookup result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkvc_checker #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   lkvc_req_if                        req_mon,
   lkvc_rsp_if                        rsp_mon,
   input  logic                       csr_wr_en,
   input  logic [lkvc_pkg::CAP_W-1:0] csr_wr_data,
   output int                         mismatches,
   output int                         open_gets,
   output int                         lookups_seen,
   output int                         hits_seen
);
   import lkvc_pkg::*;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic              found;
      logic [DATA_W-1:0] read_value;
   } lookup_word_type;

   lookup_word_type   lookups_due[$];

   logic [DATA_W-1:0] slot_key[ENTRIES];
   logic [DATA_W-1:0] slot_data[ENTRIES];
   bit                slot_live[ENTRIES];
   int unsigned       slot_age[ENTRIES];
   int unsigned       live_count;
   logic [CAP_W-1:0]  capacity_reg;

   function automatic int find_slot(logic [DATA_W-1:0] k);
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_live[i] && slot_key[i] == k) return i;
      end
      return -1;
   endfunction

   function automatic void promote_slot(int idx);
      int unsigned r;
      r = slot_age[idx];
      for (int j = 0; j < ENTRIES; j++) begin
         if (slot_live[j] && slot_age[j] < r) slot_age[j]++;
      end
      slot_age[idx] = 0;
   endfunction

   function automatic void drop_oldest();
      if (live_count == 0) return;
      for (int j = 0; j < ENTRIES; j++) begin
         if (slot_live[j] && slot_age[j] == live_count - 1) begin
            slot_live[j] = 1'b0;
            slot_age[j]  = 0;
            live_count--;
            return;
         end
      end
   endfunction

   function automatic void store_new(logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
      int unsigned limit;
      int          free_slot;
      limit = capacity_reg;
      if (limit == 0) limit = 1;
      if (limit > ENTRIES) limit = ENTRIES;
      // a lowered capacity is only enforced here, on the next insertion
      while (live_count >= limit && live_count > 0) drop_oldest();
      free_slot = -1;
      for (int j = 0; j < ENTRIES; j++) begin
         if (!slot_live[j] && free_slot < 0) free_slot = j;
      end
      if (free_slot < 0) return;
      for (int j = 0; j < ENTRIES; j++) begin
         if (slot_live[j]) slot_age[j]++;
      end
      slot_key[free_slot]  = k;
      slot_data[free_slot] = v;
      slot_live[free_slot] = 1'b1;
      slot_age[free_slot]  = 0;
      live_count++;
   endfunction

   function automatic void apply_word(logic act, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
      int              idx;
      lookup_word_type due;
      idx = find_slot(k);
      if (act == ACT_SET) begin
         if (idx >= 0) begin
            slot_data[idx] = v;
            promote_slot(idx);
         end else begin
            store_new(k, v);
         end
      end else begin
         lookups_seen++;
         if (idx >= 0) begin
            due.found      = 1'b1;
            due.read_value = slot_data[idx];
            promote_slot(idx);
            hits_seen++;
         end else begin
            due.found      = 1'b0;
            due.read_value = '0;
         end
         lookups_due.push_back(due);
      end
   endfunction

   always @(posedge clock) begin
      lookup_word_type due;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            slot_key[i]  = '0;
            slot_data[i] = '0;
            slot_live[i] = 1'b0;
            slot_age[i]  = 0;
         end
         live_count   = 0;
         capacity_reg = CAP_RESET;
         lookups_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (lookups_due.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("lkvc_checker: unexpected word: found %0b read_value %h",
                           rsp_mon.found, rsp_mon.read_value);
            end else begin
               due = lookups_due.pop_front();
               if (rsp_mon.found !== due.found || rsp_mon.read_value !== due.read_value) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("lkvc_checker: found exp %0b got %0b, value exp %h got %h",
                              due.found, rsp_mon.found, due.read_value, rsp_mon.read_value);
               end
            end
         end
         if (csr_wr_en) capacity_reg = csr_wr_data;
         if (req_mon.valid && req_mon.ready)
            apply_word(req_mon.action, req_mon.lookup_key, req_mon.write_value);
      end
      open_gets <= lookups_due.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// lru key/value cache testbench
// directed get/set words on extreme keys and values and on capacity corner
// cases, then random phases over a small key pool per capacity setting, with
// idling on either side and a checker predicting every lookup response
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import lkvc_pkg::*;

   localparam int DRAIN_CYCLES   = 2 * ENTRIES_DEF + 12;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_WORDS    = 168;
   localparam int POOL_MAX       = 24;

   localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
   localparam logic [DATA_W-1:0] MOST_POS = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] ALL_ONES = 32'hffff_ffff;
   localparam logic [DATA_W-1:0] ZERO     = 32'h0000_0000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;

   int tx_idle_pct;
   int rx_idle_pct;
   int words_sent;
   int cap_settings;
   int quiet_cycles;
   int mismatches;
   int open_gets;
   int lookups_seen;
   int hits_seen;

   logic [DATA_W-1:0] key_pool[POOL_MAX];
   int                pool_size;
   logic [DATA_W-1:0] corner_values[4] = '{ZERO, MOST_POS, MOST_NEG, ALL_ONES};
   int                cap_plan[RANDOM_PHASES] = '{16, 1, 31, 4, 0, 2, 16, 9, 15, 16};

   lkvc_req_if req_bus ();
   lkvc_rsp_if rsp_bus ();

   lru_key_value_cache dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   lkvc_checker cache_monitor (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .mismatches   (mismatches),
      .open_gets    (open_gets),
      .lookups_seen (lookups_seen),
      .hits_seen    (hits_seen)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   task automatic send_word(logic act, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.action      <= act;
      req_bus.lookup_key  <= k;
      req_bus.write_value <= v;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words_sent++;
   endtask

   // sets give no response, so hold off long enough for a last sweep to finish
   task automatic drain_cache();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (open_gets != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(logic [CAP_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cap_settings++;
   endtask

   initial begin
      req_bus.valid       <= 1'b0;
      req_bus.action      <= ACT_GET;
      req_bus.lookup_key  <= '0;
      req_bus.write_value <= '0;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      tx_idle_pct = 20;
      rx_idle_pct = 78;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty cache, extreme keys and values, head key rewritten
      send_word(ACT_GET, ZERO, ZERO);
      send_word(ACT_SET, MOST_NEG, MOST_POS);
      send_word(ACT_SET, MOST_POS, MOST_NEG);
      send_word(ACT_SET, ALL_ONES, ALL_ONES);
      send_word(ACT_SET, ZERO, ZERO);
      send_word(ACT_GET, MOST_NEG, ZERO);
      send_word(ACT_GET, MOST_POS, ZERO);
      send_word(ACT_GET, ALL_ONES, ZERO);
      send_word(ACT_GET, ZERO, ZERO);
      send_word(ACT_SET, ZERO, 32'h1234_5678);
      send_word(ACT_SET, ZERO, ZERO);
      send_word(ACT_GET, ZERO, ALL_ONES);
      send_word(ACT_GET, 32'h0000_0001, ZERO);
      send_word(ACT_GET, MOST_POS, 32'hdead_beef);

      // capacity lowered below the entries held
      drain_cache();
      set_capacity(5'd2);
      send_word(ACT_GET, MOST_NEG, ZERO);
      send_word(ACT_GET, ALL_ONES, ZERO);
      send_word(ACT_SET, 32'h0000_0005, 32'h0000_0037);
      send_word(ACT_GET, ZERO, ZERO);
      send_word(ACT_GET, 32'h0000_0005, ZERO);

      // zero capacity behaves as one
      drain_cache();
      set_capacity(5'd0);
      send_word(ACT_SET, 32'h0000_0009, 32'h0000_0063);
      send_word(ACT_GET, 32'h0000_0005, ZERO);
      send_word(ACT_GET, 32'h0000_0009, ZERO);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         int eff;
         if (p == 4) begin
            tx_idle_pct = 78;
            rx_idle_pct = 20;
         end else if (p == 7) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         drain_cache();
         set_capacity(cap_plan[p][CAP_W-1:0]);
         eff = cap_plan[p];
         if (eff == 0) eff = 1;
         if (eff > ENTRIES_DEF) eff = ENTRIES_DEF;
         pool_size = eff + $urandom_range(1, 6);
         foreach (key_pool[i]) key_pool[i] = $urandom;
         key_pool[0] = corner_values[p % 4];
         repeat (PHASE_WORDS) begin
            logic              act;
            logic [DATA_W-1:0] k;
            logic [DATA_W-1:0] v;
            act = $urandom_range(0, 1) ? ACT_SET : ACT_GET;
            if ($urandom_range(0, 9) == 0) k = $urandom;
            else k = key_pool[$urandom_range(0, pool_size - 1)];
            if ($urandom_range(0, 15) == 0) v = corner_values[$urandom_range(0, 3)];
            else v = $urandom;
            send_word(act, k, v);
         end
      end

      drain_cache();
      $display("summary: %0d request words, %0d lookups with %0d hits, %0d capacity settings",
               words_sent, lookups_seen, hits_seen, cap_settings);
      $display("summary: sender-heavy, receiver-heavy and back-to-back idling phases run");
      if (mismatches == 0 && open_gets == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
